FILE: rtl/core/qph_pkg.sv
// shared types and constants for the quadratic probe hash table
`timescale 1ns / 1ps

package qph_pkg;

    // fixed field widths of the transactions
    localparam int KEY_IN_W   = 32;
    localparam int ACT_W      = 2;
    localparam int STATUS_W   = 3;
    localparam int IDX_OUT_W  = 4;

    // key reduction takes two steps: reciprocal multiply, then low-bit correction
    localparam int MOD_STEPS  = 2;
    localparam int STEP_W     = 1;

    // command queue between front and back
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = 1;
    localparam int CMDQ_CNT_W = 2;

    // result queue at the output
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = 2;
    localparam int OUTQ_CNT_W = 3;

    typedef enum logic [ACT_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_SEARCH = 2'd1,
        ACT_DUMP   = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_FULL     = 3'd1,
        ST_FOUND    = 3'd2,
        ST_MISSING  = 3'd3,
        ST_DUMP     = 3'd4
    } status_t;

    typedef struct packed {
        logic [ACT_W-1:0]    action;
        logic [KEY_IN_W-1:0] key;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [IDX_OUT_W-1:0] slot_index;
        logic [KEY_IN_W-1:0]  slot_value;
        logic                 last;
    } out_item_t;

    typedef enum logic [1:0] {
        F_IDLE = 2'd0,
        F_MOD  = 2'd1,
        F_SEND = 2'd2
    } front_state_t;

    typedef enum logic [1:0] {
        B_CLEAR = 2'd0,
        B_IDLE  = 2'd1,
        B_PROBE = 2'd2,
        B_DUMP  = 2'd3
    } back_state_t;

endpackage

FILE: rtl/core/qph_cmd_q.sv
// two-entry command queue between the front and back parts
`timescale 1ns / 1ps

module qph_cmd_q #(
    parameter int W = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    output logic         valid,
    output logic [W-1:0] head_data,
    input  logic         pop
);
    import qph_pkg::*;

    logic [W-1:0]          entry_reg [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] wr_ptr_reg;
    logic [CMDQ_PTR_W-1:0] wr_ptr_next;
    logic [CMDQ_PTR_W-1:0] rd_ptr_reg;
    logic [CMDQ_PTR_W-1:0] rd_ptr_next;
    logic [CMDQ_CNT_W-1:0] cnt_reg;
    logic [CMDQ_CNT_W-1:0] cnt_next;
    logic                  do_push;
    logic                  do_pop;

    assign full      = (cnt_reg == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign valid     = (cnt_reg != '0);
    assign head_data = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && valid;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/core/qph_front.sv
// front part: takes input transactions, masks the key and reduces it to its home slot
`timescale 1ns / 1ps

module qph_front #(
    parameter int SLOTS = 16,
    parameter int KW    = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  qph_pkg::in_item_t              item,
    input  logic                           clearing,
    output logic                           q_push,
    output logic [qph_pkg::ACT_W+KW+$clog2(SLOTS)-1:0] q_data,
    input  logic                           q_full
);
    import qph_pkg::*;

    localparam int IW      = $clog2(SLOTS);
    localparam int RECIP_W = KEY_IN_W + 1;
    localparam int PROD_W  = KEY_IN_W + RECIP_W;

    // ceil(2^(KEY_IN_W+IW) / SLOTS) gives the exact quotient for every key
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << (KEY_IN_W + IW)) + 64'(SLOTS) - 64'd1) / 64'(SLOTS));
    localparam logic [IW-1:0] S_LOW = IW'(SLOTS);

    front_state_t         state_reg;
    front_state_t         state_next;
    action_t              act_reg;
    action_t              act_next;
    logic [KW-1:0]        key_reg;
    logic [KW-1:0]        key_next;
    logic [KEY_IN_W-1:0]  sh_reg;
    logic [KEY_IN_W-1:0]  sh_next;
    logic [IW-1:0]        quot_reg;
    logic [IW-1:0]        quot_next;
    logic [IW-1:0]        rem_reg;
    logic [IW-1:0]        rem_next;
    logic [STEP_W-1:0]    step_reg;
    logic [STEP_W-1:0]    step_next;
    logic                 accept;
    logic [KW-1:0]        key_in;
    logic [PROD_W-1:0]    prod;
    logic [IW-1:0]        corr;

    assign full   = (state_reg != F_IDLE) || clearing;
    assign accept = push && !full;
    assign key_in = item.key[KW-1:0];
    assign q_data = {act_reg, key_reg, rem_reg};

    // quotient by reciprocal multiply, remainder from the low bits only
    always_comb
    begin
        prod = PROD_W'(sh_reg) * PROD_W'(RECIP);
        corr = IW'(quot_reg * S_LOW);
    end

    // next state and outputs
    always_comb
    begin
        state_next = state_reg;
        act_next   = act_reg;
        key_next   = key_reg;
        sh_next    = sh_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        q_push     = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    act_next  = action_t'(item.action);
                    key_next  = key_in;
                    sh_next   = KEY_IN_W'(key_in);
                    rem_next  = '0;
                    step_next = '0;
                    unique case (action_t'(item.action))
                        ACT_INSERT, ACT_SEARCH: state_next = F_MOD;
                        ACT_DUMP:               state_next = F_SEND;
                        ACT_NONE:               state_next = F_IDLE;
                    endcase
                end
            end
            F_MOD:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(MOD_STEPS - 1))
                begin
                    rem_next   = sh_reg[IW-1:0] - corr;
                    state_next = F_SEND;
                end
                else
                begin
                    quot_next = prod[KEY_IN_W+IW +: IW];
                end
            end
            F_SEND:
            begin
                q_push = 1'b1;
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // item payload and reduction registers
    always_ff @(posedge clk)
    begin
        act_reg  <= act_next;
        key_reg  <= key_next;
        sh_reg   <= sh_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    // remainder stays a valid slot once reduction runs
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == F_SEND) && (act_reg != ACT_DUMP) |-> ({1'b0, rem_reg} < (IW+1)'(SLOTS)))
        else $error("home slot out of range");

endmodule

FILE: rtl/core/qph_back.sv
// back part: slot memory, clearing pass, probe walk, dump and result queue
`timescale 1ns / 1ps

module qph_back #(
    parameter int SLOTS = 16,
    parameter int KW    = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cmd_valid,
    input  logic [qph_pkg::ACT_W+KW+$clog2(SLOTS)-1:0] cmd_data,
    output logic                           cmd_pop,
    output logic                           clearing,
    output logic                           empty,
    input  logic                           pop,
    output qph_pkg::out_item_t             result
);
    import qph_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam logic [IW:0]   S_EXT   = (IW+1)'(SLOTS);
    localparam logic [IW:0]   S_LAST  = (IW+1)'(SLOTS - 1);
    localparam logic [IW-1:0] ODD_ONE = IW'(3 % SLOTS);

    // slot memory
    logic [KW-1:0] mem [SLOTS];
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [KW-1:0] mem_wdata;
    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic [KW-1:0] rd_data_reg;

    // command fields
    action_t       cmd_act;
    logic [KW-1:0] cmd_key;
    logic [IW-1:0] cmd_home;

    // walk state
    back_state_t   state_reg;
    back_state_t   state_next;
    action_t       act_reg;
    action_t       act_next;
    logic [KW-1:0] key_reg;
    logic [KW-1:0] key_next;
    logic [IW-1:0] home_reg;
    logic [IW-1:0] home_next;
    logic [IW:0]   i_reg;
    logic [IW:0]   i_next;
    logic [IW-1:0] sq_reg;
    logic [IW-1:0] sq_next;
    logic [IW-1:0] odd_reg;
    logic [IW-1:0] odd_next;
    logic [IW-1:0] rd_slot_reg;
    logic [IW-1:0] rd_slot_next;
    logic          rd_last_reg;
    logic          rd_last_next;
    logic          pend_reg;
    logic          pend_next;

    // probe arithmetic
    logic [IW:0]   addr_sum;
    logic [IW-1:0] probe_addr;
    logic [IW:0]   sq_sum;
    logic [IW:0]   odd_sum;
    logic          hit;
    logic [IW+3:0] slot_ext;

    // result queue
    out_item_t             outq_reg [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] owr_reg;
    logic [OUTQ_PTR_W-1:0] ord_reg;
    logic [OUTQ_CNT_W-1:0] ocnt_reg;
    logic [OUTQ_CNT_W-1:0] ocnt_next;
    logic                  res_push;
    out_item_t             res_data;
    logic                  res_pop;
    logic                  dump_issue;

    assign cmd_act  = action_t'(cmd_data[ACT_W+KW+IW-1 -: ACT_W]);
    assign cmd_key  = cmd_data[KW+IW-1:IW];
    assign cmd_home = cmd_data[IW-1:0];
    assign clearing = (state_reg == B_CLEAR);

    // next probe slot and quadratic step update
    always_comb
    begin
        addr_sum   = {1'b0, home_reg} + {1'b0, sq_reg};
        probe_addr = (addr_sum >= S_EXT) ? IW'(addr_sum - S_EXT) : addr_sum[IW-1:0];
        sq_sum     = {1'b0, sq_reg} + {1'b0, odd_reg};
        odd_sum    = {1'b0, odd_reg} + (IW+1)'(2);
    end

    assign hit      = (act_reg == ACT_INSERT) ? (rd_data_reg == '0) : (rd_data_reg == key_reg);
    assign slot_ext = {4'b0000, rd_slot_reg};
    assign dump_issue = (i_reg < S_EXT) &&
                        ((ocnt_reg + OUTQ_CNT_W'(pend_reg)) < OUTQ_CNT_W'(OUTQ_DEPTH));

    // next state and outputs
    always_comb
    begin
        state_next   = state_reg;
        act_next     = act_reg;
        key_next     = key_reg;
        home_next    = home_reg;
        i_next       = i_reg;
        sq_next      = sq_reg;
        odd_next     = odd_reg;
        rd_slot_next = rd_slot_reg;
        rd_last_next = rd_last_reg;
        pend_next    = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = rd_slot_reg;
        mem_wdata    = key_reg;
        rd_en        = 1'b0;
        rd_addr      = probe_addr;
        res_push     = 1'b0;
        res_data     = '0;
        cmd_pop      = 1'b0;
        unique case (state_reg)
            B_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = i_reg[IW-1:0];
                mem_wdata = '0;
                i_next    = i_reg + 1'b1;
                if (i_reg == S_LAST)
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (cmd_valid && (cmd_act == ACT_DUMP))
                begin
                    cmd_pop    = 1'b1;
                    act_next   = cmd_act;
                    i_next     = '0;
                    state_next = B_DUMP;
                end
                else if (cmd_valid && (ocnt_reg < OUTQ_CNT_W'(OUTQ_DEPTH)))
                begin
                    cmd_pop      = 1'b1;
                    act_next     = cmd_act;
                    key_next     = cmd_key;
                    home_next    = cmd_home;
                    rd_en        = 1'b1;
                    rd_addr      = cmd_home;
                    rd_slot_next = cmd_home;
                    rd_last_next = 1'b0;
                    i_next       = (IW+1)'(1);
                    sq_next      = IW'(1);
                    odd_next     = ODD_ONE;
                    state_next   = B_PROBE;
                end
            end
            B_PROBE:
            begin
                if (hit)
                begin
                    res_data.status     = (act_reg == ACT_INSERT) ? ST_INSERTED : ST_FOUND;
                    res_data.slot_index = slot_ext[IDX_OUT_W-1:0];
                    res_data.slot_value = KEY_IN_W'(key_reg);
                    res_data.last       = 1'b1;
                    res_push            = 1'b1;
                    mem_we              = (act_reg == ACT_INSERT);
                    state_next          = B_IDLE;
                end
                else if (rd_last_reg)
                begin
                    res_data.status = (act_reg == ACT_INSERT) ? ST_FULL : ST_MISSING;
                    res_data.last   = 1'b1;
                    res_push        = 1'b1;
                    state_next      = B_IDLE;
                end
                else
                begin
                    rd_en        = 1'b1;
                    rd_slot_next = probe_addr;
                    rd_last_next = (i_reg == S_LAST);
                    i_next       = i_reg + 1'b1;
                    sq_next      = (sq_sum >= S_EXT) ? IW'(sq_sum - S_EXT) : sq_sum[IW-1:0];
                    odd_next     = (odd_sum >= S_EXT) ? IW'(odd_sum - S_EXT) : odd_sum[IW-1:0];
                end
            end
            B_DUMP:
            begin
                if (pend_reg)
                begin
                    res_data.status     = ST_DUMP;
                    res_data.slot_index = slot_ext[IDX_OUT_W-1:0];
                    res_data.slot_value = KEY_IN_W'(rd_data_reg);
                    res_data.last       = rd_last_reg;
                    res_push            = 1'b1;
                    if (rd_last_reg)
                    begin
                        state_next = B_IDLE;
                    end
                end
                if (dump_issue)
                begin
                    rd_en        = 1'b1;
                    rd_addr      = i_reg[IW-1:0];
                    rd_slot_next = i_reg[IW-1:0];
                    rd_last_next = (i_reg == S_LAST);
                    i_next       = i_reg + 1'b1;
                    pend_next    = 1'b1;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= B_CLEAR;
            i_reg       <= '0;
            pend_reg    <= 1'b0;
            rd_last_reg <= 1'b0;
            act_reg     <= ACT_INSERT;
        end
        else
        begin
            state_reg   <= state_next;
            i_reg       <= i_next;
            pend_reg    <= pend_next;
            rd_last_reg <= rd_last_next;
            act_reg     <= act_next;
        end
    end

    // walk payload registers
    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        home_reg    <= home_next;
        sq_reg      <= sq_next;
        odd_reg     <= odd_next;
        rd_slot_reg <= rd_slot_next;
    end

    // slot memory write and registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // result queue control
    assign empty   = (ocnt_reg == '0);
    assign res_pop = pop && !empty;
    assign result  = outq_reg[ord_reg];

    always_comb
    begin
        ocnt_next = ocnt_reg;
        if (res_push && !res_pop)
        begin
            ocnt_next = ocnt_reg + 1'b1;
        end
        else if (res_pop && !res_push)
        begin
            ocnt_next = ocnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owr_reg  <= '0;
            ord_reg  <= '0;
            ocnt_reg <= '0;
        end
        else
        begin
            if (res_push)
            begin
                owr_reg <= owr_reg + 1'b1;
            end
            if (res_pop)
            begin
                ord_reg <= ord_reg + 1'b1;
            end
            ocnt_reg <= ocnt_next;
        end
    end

    // result queue storage
    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            outq_reg[owr_reg] <= res_data;
        end
    end

    // a result is only produced when the result queue has room
    a_outq_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (ocnt_reg < OUTQ_CNT_W'(OUTQ_DEPTH)))
        else $error("result queue overflow");

    // the table is only written by the clearing pass or an insert hit
    a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == B_CLEAR) ||
                   ((state_reg == B_PROBE) && (act_reg == ACT_INSERT) && hit))
        else $error("unexpected table write");

    // no command leaves the queue during the clearing pass
    a_clear_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_CLEAR) |-> !cmd_pop)
        else $error("command taken while clearing");

endmodule

FILE: rtl/core/quadratic_probe_hash_table_top.sv
// top level of the quadratic probe hash table
//
//  channel   handshake      payload        direction
//  -------   ------------   ------------   ---------
//  item      push / full    in_item_t      into block
//  result    pop / empty    out_item_t     out of block
//
// after reset a clearing pass zeroes every slot of the table with full held high
// insert and search: the front accepts, then holds full through reciprocal multiply,
// correction and hand-off; the back probes one slot per cycle, up to SLOTS slots
// dump: the front goes straight to hand-off; the back reads one slot per cycle while the
// result queue has room; front and back overlap through a two-entry command queue; a full
// result queue stalls the back, which then backs up the queue and the input
`timescale 1ns / 1ps

module quadratic_probe_hash_table_top #(
    parameter int SLOTS    = 16,
    parameter int KEY_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  qph_pkg::in_item_t  item,
    output logic               empty,
    input  logic               pop,
    output qph_pkg::out_item_t result
);
    import qph_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int KW = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W;
    localparam int CW = ACT_W + KW + IW;

    logic          clearing;
    logic          fq_push;
    logic [CW-1:0] fq_data;
    logic          fq_full;
    logic          qb_valid;
    logic [CW-1:0] qb_data;
    logic          qb_pop;

    // front: accept and key reduction
    qph_front #(
        .SLOTS (SLOTS),
        .KW    (KW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .item     (item),
        .clearing (clearing),
        .q_push   (fq_push),
        .q_data   (fq_data),
        .q_full   (fq_full)
    );

    // command queue between front and back
    qph_cmd_q #(
        .W (CW)
    ) u_cmd_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fq_push),
        .push_data (fq_data),
        .full      (fq_full),
        .valid     (qb_valid),
        .head_data (qb_data),
        .pop       (qb_pop)
    );

    // back: table access and results
    qph_back #(
        .SLOTS (SLOTS),
        .KW    (KW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (qb_valid),
        .cmd_data  (qb_data),
        .cmd_pop   (qb_pop),
        .clearing  (clearing),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

FILE: verif/qph_table_checker.sv
// checker for the quadratic probe hash table: shadow table, expected results, comparison
`timescale 1ns / 1ps

module qph_table_checker #(
    parameter int SLOTS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic               full,
    input  qph_pkg::in_item_t  item,
    input  logic               empty,
    input  logic               pop,
    input  qph_pkg::out_item_t result,
    output int                 mismatch_count,
    output int                 pending_results
);
    import qph_pkg::*;

    // shadow copy of the slot table and the results still owed by the block
    logic [KEY_IN_W-1:0] shadow_slots [SLOTS];
    out_item_t           owed_results [$];

    // slot visited by probe number step for a given key
    function automatic int probe_slot(logic [KEY_IN_W-1:0] key, int step);
        int home;
        home = int'(key % SLOTS);
        return (home + (step * step) % SLOTS) % SLOTS;
    endfunction

    function automatic out_item_t make_result(status_t st, int idx,
                                              logic [KEY_IN_W-1:0] val, logic is_last);
        out_item_t r;
        r.status     = st;
        r.slot_index = idx[IDX_OUT_W-1:0];
        r.slot_value = val;
        r.last       = is_last;
        return r;
    endfunction

    // apply one accepted transaction to the shadow table and queue what it produces
    function automatic void predict_table_op(in_item_t t);
        int  s;
        bit  done;
        done = 1'b0;
        case (action_t'(t.action))
            ACT_INSERT:
            begin
                for (int i = 0; i < SLOTS && !done; i++)
                begin
                    s = probe_slot(t.key, i);
                    if (shadow_slots[s] == '0)
                    begin
                        shadow_slots[s] = t.key;
                        owed_results.push_back(make_result(ST_INSERTED, s, t.key, 1'b1));
                        done = 1'b1;
                    end
                end
                if (!done)
                    owed_results.push_back(make_result(ST_FULL, 0, '0, 1'b1));
            end
            ACT_SEARCH:
            begin
                // search keeps probing past empty slots
                for (int i = 0; i < SLOTS && !done; i++)
                begin
                    s = probe_slot(t.key, i);
                    if (shadow_slots[s] == t.key)
                    begin
                        owed_results.push_back(make_result(ST_FOUND, s, t.key, 1'b1));
                        done = 1'b1;
                    end
                end
                if (!done)
                    owed_results.push_back(make_result(ST_MISSING, 0, '0, 1'b1));
            end
            ACT_DUMP:
            begin
                for (int i = 0; i < SLOTS; i++)
                    owed_results.push_back(make_result(ST_DUMP, i, shadow_slots[i],
                                                       i == SLOTS - 1));
            end
            default:
            begin
                // unknown action leaves the table alone and yields nothing
            end
        endcase
    endfunction

    // compare one accepted result transaction against the oldest owed one
    function automatic void check_result(out_item_t got);
        out_item_t want;
        if (owed_results.size() == 0)
        begin
            $error("unexpected result: status %0d slot_index %0d slot_value %0h last %0d",
                   got.status, got.slot_index, got.slot_value, got.last);
            mismatch_count++;
            return;
        end
        want = owed_results.pop_front();
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            mismatch_count++;
        end
        if (got.slot_index !== want.slot_index)
        begin
            $error("slot_index: expected %0d, actual %0d", want.slot_index, got.slot_index);
            mismatch_count++;
        end
        if (got.slot_value !== want.slot_value)
        begin
            $error("slot_value: expected %0h, actual %0h", want.slot_value, got.slot_value);
            mismatch_count++;
        end
        if (got.last !== want.last)
        begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            mismatch_count++;
        end
    endfunction

    // watch both channels at every edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                shadow_slots[i] = '0;
            owed_results.delete();
            mismatch_count  = 0;
            pending_results = 0;
        end
        else
        begin
            if (pop && !empty)
                check_result(result);
            if (push && !full)
                predict_table_op(item);
            pending_results = owed_results.size();
        end
    end

endmodule

FILE: verif/quadratic_probe_hash_table_top_tb.sv
// testbench top for the quadratic probe hash table: stimulus, flow control and verdict
`timescale 1ns / 1ps

module quadratic_probe_hash_table_top_tb;
    import qph_pkg::*;

    localparam int SLOTS        = 16;
    localparam int KEY_BITS     = 32;
    localparam int RANDOM_OPS   = 440;
    localparam int IDLE_LIMIT   = 3000;
    localparam int DRAIN_CYCLES = 64;
    localparam int HOLD_AFTER   = 120;
    localparam int HOLD_CYCLES  = 500;

    logic      clk;
    logic      rst_n;
    logic      push;
    logic      full;
    in_item_t  item;
    logic      empty;
    logic      pop;
    out_item_t result;

    int mismatch_count;
    int pending_results;
    int items_accepted;
    int idle_cycles;

    // keys offered for insertion, reused as search keys
    logic [KEY_IN_W-1:0] inserted_keys [$];

    quadratic_probe_hash_table_top #(
        .SLOTS    (SLOTS),
        .KEY_BITS (KEY_BITS)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    qph_table_checker #(
        .SLOTS (SLOTS)
    ) u_table_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .item            (item),
        .empty           (empty),
        .pop             (pop),
        .result          (result),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog on cycles without any accepted transaction
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // offer one transaction and hold it until the block takes it
    task automatic offer_op(action_t act, logic [KEY_IN_W-1:0] key);
        push        <= 1'b1;
        item.action <= act;
        item.key    <= key;
        do
            @(posedge clk);
        while (full);
        items_accepted++;
        if (act == ACT_INSERT)
            inserted_keys.push_back(key);
    endtask

    task automatic pause_sender(int cycles);
        if (cycles > 0)
        begin
            push <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // mostly colliding small keys, some zero, some fully random
    function automatic logic [KEY_IN_W-1:0] pick_insert_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return $urandom_range(0, 47);
        else if (r < 60)
            return '0;
        else
            return $urandom;
    endfunction

    // searches lean on keys already offered for insertion
    function automatic logic [KEY_IN_W-1:0] pick_search_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50 && inserted_keys.size() > 0)
            return inserted_keys[$urandom_range(0, inserted_keys.size() - 1)];
        else if (r < 60)
            return '0;
        else if (r < 80)
            return $urandom_range(0, 47);
        else
            return $urandom;
    endfunction

    // receiver: pop rate changes in runs, plus one long hold-off to back up the block
    initial
    begin
        int  pop_pct;
        int  run_len;
        bit  held_once;
        pop       <= 1'b0;
        held_once = 1'b0;
        @(posedge rst_n);
        forever
        begin
            case ($urandom_range(0, 2))
                0:       pop_pct = 100;
                1:       pop_pct = 60;
                default: pop_pct = 25;
            endcase
            run_len = $urandom_range(16, 96);
            repeat (run_len)
            begin
                @(posedge clk);
                if (!held_once && items_accepted >= HOLD_AFTER)
                begin
                    held_once = 1'b1;
                    pop <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                pop <= ($urandom_range(1, 100) <= pop_pct);
            end
        end
    end

    // stimulus and verdict
    initial
    begin
        int       ops_sent;
        int       burst_len;
        int       r;
        action_t  act;
        logic [KEY_IN_W-1:0] key;

        rst_n          = 1'b0;
        push           <= 1'b0;
        item           <= '0;
        items_accepted = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty table, zero key, collisions up to a full probe chain
        offer_op(ACT_DUMP,   32'h0000_0000);
        pause_sender($urandom_range(0, 3));
        offer_op(ACT_SEARCH, 32'h0000_0000);
        offer_op(ACT_SEARCH, 32'h1234_5678);
        pause_sender($urandom_range(0, 3));
        offer_op(ACT_INSERT, 32'h0000_0000);
        offer_op(ACT_INSERT, 32'h0000_0010);
        offer_op(ACT_INSERT, 32'h0000_0020);
        pause_sender($urandom_range(0, 3));
        offer_op(ACT_INSERT, 32'h0000_0030);
        offer_op(ACT_INSERT, 32'h0000_0040);
        // home slot zero chain is now occupied
        offer_op(ACT_INSERT, 32'h0000_0050);
        offer_op(ACT_INSERT, 32'h0000_0000);
        pause_sender($urandom_range(0, 3));
        offer_op(ACT_SEARCH, 32'h0000_0040);
        offer_op(ACT_SEARCH, 32'h0000_0000);
        offer_op(ACT_SEARCH, 32'h0000_0050);
        offer_op(ACT_NONE,   32'hFFFF_FFFF);
        pause_sender($urandom_range(0, 3));
        offer_op(ACT_INSERT, 32'hFFFF_FFFF);
        offer_op(ACT_INSERT, 32'hAAAA_AAAA);
        offer_op(ACT_INSERT, 32'h5555_5555);
        offer_op(ACT_INSERT, 32'h0000_000F);
        pause_sender($urandom_range(0, 3));
        offer_op(ACT_SEARCH, 32'hFFFF_FFFF);
        offer_op(ACT_SEARCH, 32'h0000_000F);
        offer_op(ACT_SEARCH, 32'h8000_0000);
        offer_op(ACT_DUMP,   32'hFFFF_FFFF);
        offer_op(ACT_NONE,   32'h0000_0000);

        // random traffic in bursts with random gaps
        ops_sent = 0;
        while (ops_sent < RANDOM_OPS)
        begin
            burst_len = $urandom_range(1, 10);
            repeat (burst_len)
            begin
                r = $urandom_range(0, 99);
                if (r < 35)
                begin
                    act = ACT_INSERT;
                    key = pick_insert_key();
                end
                else if (r < 75)
                begin
                    act = ACT_SEARCH;
                    key = pick_search_key();
                end
                else if (r < 92)
                begin
                    act = ACT_DUMP;
                    key = $urandom;
                end
                else
                begin
                    act = ACT_NONE;
                    key = $urandom;
                end
                offer_op(act, key);
                ops_sent++;
            end
            if ($urandom_range(0, 3) == 0)
                pause_sender(0);
            else
                pause_sender($urandom_range(1, 12));
        end
        push <= 1'b0;

        // drain and let any stray result show up
        @(posedge clk);
        wait (pending_results == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_results == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
